// ===== hdl/gfmg_pkg.sv =====
// shared constants, types and a helper function of the gaussian factor mean gradient block
package gfmg_pkg;

  localparam int FRAC_BITS = 16;

  // field widths
  localparam int XW   = 32;
  localparam int TAUW = 31;
  localparam int GW   = FRAC_BITS + 1;
  localparam int AUW  = 32;
  localparam int SQW  = 2 * AUW;
  localparam int U2W  = SQW - FRAC_BITS;
  localparam int PLW  = U2W / 2;
  localparam int PHW  = U2W - PLW;
  localparam int PW   = TAUW + U2W;
  localparam int PEW  = PW - FRAC_BITS - 1;

  // exp core in Q30
  localparam int     QB      = 30;
  localparam int     PB      = QB + 1;
  localparam int     RW      = QB;
  localparam longint LN2_Q30 = 64'd744261118;
  localparam longint E_MAX   = longint'(FRAC_BITS) * LN2_Q30;
  localparam int     ESH     = QB - FRAC_BITS;
  localparam longint C_LIM   = E_MAX >> ESH;
  localparam int     EW      = $clog2(E_MAX + 1);
  localparam int     EXW     = EW - ESH;
  localparam int     KW      = $clog2(FRAC_BITS + 1);
  localparam int     SW      = $clog2(QB + 1);
  localparam int     NSTEPS  = 9;
  localparam int     NW      = $clog2(NSTEPS + 1);
  localparam int     RECIP_SH = 32;
  localparam int     MW      = RECIP_SH + 1;
  localparam int     TW      = QB + MW;

  localparam logic [PB-1:0]   ONE_Q     = PB'(1) << QB;
  localparam logic [TAUW-1:0] TAU_RESET = TAUW'(1) << FRAC_BITS;
  localparam logic [XW-1:0]   SAT_NEG   = {1'b1, {(XW - 1){1'b0}}};
  localparam logic [XW-1:0]   SAT_POS   = {1'b0, {(XW - 1){1'b1}}};

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_IW-1:0] REG_MEAN = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_PREC = CFG_IW'(1);

  // per-item side data carried along the pipe
  typedef struct packed {
    logic [AUW-1:0] au;
    logic           neg;
    logic           mode;
    logic [U2W-1:0] u2;
    logic           zero;
    logic [KW-1:0]  k;
  } side_t;

  typedef struct packed {
    logic [GW-1:0] mean;
    logic [XW-1:0] grad_mu;
    logic [XW-1:0] grad_tau;
    logic          mode;
  } res_t;

  // floor(2^32 / n) for the horner divisors
  function automatic logic [MW-1:0] recip(input logic [NW-1:0] n);
    logic [MW-1:0] m;
    case (n)
      NW'(1):  m = MW'(64'd4294967296);
      NW'(2):  m = MW'(64'd2147483648);
      NW'(3):  m = MW'(64'd1431655765);
      NW'(4):  m = MW'(64'd1073741824);
      NW'(5):  m = MW'(64'd858993459);
      NW'(6):  m = MW'(64'd715827882);
      NW'(7):  m = MW'(64'd613566756);
      NW'(8):  m = MW'(64'd536870912);
      NW'(9):  m = MW'(64'd477218588);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/gfmg_exp_step.sv =====
// one horner step of the exp polynomial: p = 1 - ((r * p) >> 30) / n over three stages
module gfmg_exp_step (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [gfmg_pkg::NW-1:0] n_i,
  input  logic [gfmg_pkg::RW-1:0] r_i,
  input  logic [gfmg_pkg::PB-1:0] p_i,
  input  gfmg_pkg::side_t         side_i,
  output logic                    vld_o,
  output logic [gfmg_pkg::RW-1:0] r_o,
  output logic [gfmg_pkg::PB-1:0] p_o,
  output gfmg_pkg::side_t         side_o
);
  import gfmg_pkg::*;

  logic                 a_vld_q, b_vld_q, c_vld_q;
  logic [RW-1:0]        a_r_q, b_r_q, c_r_q;
  side_t                a_side_q, b_side_q, c_side_q;
  logic [RW+PB-1:0]     a_mr_d, a_mr_q;
  logic [QB-1:0]        b_q_d, b_q_q;
  logic [TW-1:0]        b_t_d, b_t_q;
  logic [PB-1:0]        c_p_d, c_p_q;

  logic [QB-1:0]        qe;
  logic [QB+NW-1:0]     qn, rem;
  logic [QB-1:0]        qd;

  always_comb begin
    a_mr_d = (RW + PB)'(r_i) * (RW + PB)'(p_i);
    b_q_d  = a_mr_q[QB +: QB];
    b_t_d  = TW'(b_q_d) * TW'(recip(n_i));
    // estimate is low by at most one, fixed by the remainder
    qe     = b_t_q[RECIP_SH +: QB];
    qn     = (QB + NW)'(qe) * (QB + NW)'(n_i);
    rem    = (QB + NW)'(b_q_q) - qn;
    qd     = qe + QB'(rem >= (QB + NW)'(n_i));
    c_p_d  = ONE_Q - PB'(qd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_r_q    <= r_i;
      a_side_q <= side_i;
      a_mr_q   <= a_mr_d;
      b_r_q    <= a_r_q;
      b_side_q <= a_side_q;
      b_q_q    <= b_q_d;
      b_t_q    <= b_t_d;
      c_r_q    <= b_r_q;
      c_side_q <= b_side_q;
      c_p_q    <= c_p_d;
    end
  end

  assign vld_o  = c_vld_q;
  assign r_o    = c_r_q;
  assign p_o    = c_p_q;
  assign side_o = c_side_q;

endmodule

// ===== hdl/gfmg_kernel.sv =====
// arithmetic pipeline: offset, square, exponent, range reduction, exp, rounding and gradients
module gfmg_kernel (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             in_valid_i,
  input  logic signed [gfmg_pkg::XW-1:0]   x_value_i,
  input  logic signed [gfmg_pkg::XW-1:0]   mu_i,
  input  logic [gfmg_pkg::TAUW-1:0]        tau_i,
  output logic                             vld_o,
  output gfmg_pkg::res_t                   res_o
);
  import gfmg_pkg::*;

  localparam int MTW = U2W + GW - FRAC_BITS - 1;
  localparam int MMW = TAUW + AUW - FRAC_BITS;

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q, s8_vld_q;
  logic rd_vld_q, g1_vld_q, g2_vld_q, g3_vld_q;

  logic signed [XW:0]      s1_u_d, s1_u_q;
  side_t                   s2_side_d, s2_side_q;
  side_t                   s3_side_q;
  logic [SQW-1:0]          s3_sq_d, s3_sq_q;
  side_t                   s4_side_d, s4_side_q;
  logic [TAUW+PLW-1:0]     s4_pl_d, s4_pl_q;
  logic [TAUW+PHW-1:0]     s4_ph_d, s4_ph_q;
  side_t                   s5_side_q;
  logic [PW-1:0]           s5_prod_d, s5_prod_q;
  side_t                   s6_side_d, s6_side_q;
  logic [EW-1:0]           s6_e_d, s6_e_q;
  logic [FRAC_BITS-1:0]    s6_ge_d, s6_ge_q;
  side_t                   s7_side_d, s7_side_q;
  logic [EW-1:0]           s7_e_q;
  side_t                   s8_side_q;
  logic [RW-1:0]           s8_r_d, s8_r_q;
  logic [EW-1:0]           kln;

  logic                    h_vld [NSTEPS+1];
  logic [RW-1:0]           h_r   [NSTEPS+1];
  logic [PB-1:0]           h_p   [NSTEPS+1];
  side_t                   h_side[NSTEPS+1];

  side_t                   rd_side_q;
  logic [GW-1:0]           rd_g_d, rd_g_q;
  logic [SW-1:0]           sh;
  logic [PB:0]             rsum;

  side_t                   g1_side_q;
  logic [GW-1:0]           g1_g_q;
  logic [GW+TAUW-1:0]      g1_gtp_d, g1_gtp_q;
  logic [U2W+GW-1:0]       g1_mtp_d, g1_mtp_q;

  side_t                   g2_side_q;
  logic [GW-1:0]           g2_g_q;
  logic [TAUW+AUW-1:0]     g2_mp_d, g2_mp_q;
  logic [XW-1:0]           g2_mt_d, g2_mt_q;
  logic [MTW-1:0]          mt;

  res_t                    g3_res_d, g3_res_q;
  logic [MMW-1:0]          m;
  logic [XW-1:0]           lim, m_sat;

  always_comb begin
    // offset from the location
    s1_u_d = {x_value_i[XW-1], x_value_i} - {mu_i[XW-1], mu_i};

    // magnitude and sign
    s2_side_d      = '0;
    s2_side_d.neg  = s1_u_q[XW];
    s2_side_d.mode = (s1_u_q == '0);
    s2_side_d.au   = AUW'(s1_u_q[XW] ? -s1_u_q : s1_u_q);

    s3_sq_d = SQW'(s2_side_q.au) * SQW'(s2_side_q.au);

    // tau * u2 as two partial products
    s4_side_d    = s3_side_q;
    s4_side_d.u2 = s3_sq_q[SQW-1:FRAC_BITS];
    s4_pl_d = (TAUW + PLW)'(tau_i) * (TAUW + PLW)'(s4_side_d.u2[PLW-1:0]);
    s4_ph_d = (TAUW + PHW)'(tau_i) * (TAUW + PHW)'(s4_side_d.u2[U2W-1:PLW]);

    s5_prod_d = PW'(s4_pl_q) + (PW'(s4_ph_q) << PLW);

    // flush past the exp range, otherwise reduce by ln2
    s6_side_d      = s5_side_q;
    s6_side_d.zero = (s5_prod_q[PW-1:FRAC_BITS+1] > PEW'(C_LIM));
    s6_e_d         = {s5_prod_q[FRAC_BITS+1 +: EXW], {ESH{1'b0}}};
    for (int j = 1; j <= FRAC_BITS; j++) begin
      s6_ge_d[j-1] = (s6_e_d >= EW'(longint'(j) * LN2_Q30));
    end

    s7_side_d   = s6_side_q;
    s7_side_d.k = '0;
    for (int j = 0; j < FRAC_BITS; j++) begin
      s7_side_d.k = s7_side_d.k + KW'(s6_ge_q[j]);
    end

    kln    = EW'(s7_side_q.k) * EW'(LN2_Q30);
    s8_r_d = RW'(s7_e_q - kln);

    // round half up by 2^(30-F+k)
    sh     = SW'(ESH) + SW'(h_side[NSTEPS].k);
    rsum   = (PB + 1)'(h_p[NSTEPS]) + ((PB + 1)'(1) << (sh - SW'(1)));
    rd_g_d = h_side[NSTEPS].zero ? '0 : GW'(rsum >> sh);

    g1_gtp_d = (GW + TAUW)'(rd_g_q) * (GW + TAUW)'(tau_i);
    g1_mtp_d = (U2W + GW)'(rd_side_q.u2) * (U2W + GW)'(rd_g_q);

    g2_mp_d = (TAUW + AUW)'(g1_gtp_q[FRAC_BITS +: TAUW]) * (TAUW + AUW)'(g1_side_q.au);
    mt      = g1_mtp_q[U2W+GW-1:FRAC_BITS+1];
    g2_mt_d = (mt > MTW'(SAT_NEG)) ? SAT_NEG : XW'(mt);

    m     = g2_mp_q[TAUW+AUW-1:FRAC_BITS];
    lim   = g2_side_q.neg ? SAT_NEG : SAT_POS;
    m_sat = (m > MMW'(lim)) ? lim : XW'(m);
    g3_res_d.mean     = g2_g_q;
    g3_res_d.grad_mu  = g2_side_q.neg ? (XW'(0) - m_sat) : m_sat;
    g3_res_d.grad_tau = XW'(0) - g2_mt_q;
    g3_res_d.mode     = g2_side_q.mode;
  end

  assign h_vld[0]  = s8_vld_q;
  assign h_r[0]    = s8_r_q;
  assign h_p[0]    = ONE_Q;
  assign h_side[0] = s8_side_q;

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    gfmg_exp_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (h_vld[i]),
      .n_i    (NW'(NSTEPS - i)),
      .r_i    (h_r[i]),
      .p_i    (h_p[i]),
      .side_i (h_side[i]),
      .vld_o  (h_vld[i+1]),
      .r_o    (h_r[i+1]),
      .p_o    (h_p[i+1]),
      .side_o (h_side[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      rd_vld_q <= 1'b0;
      g1_vld_q <= 1'b0;
      g2_vld_q <= 1'b0;
      g3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
      s8_vld_q <= s7_vld_q;
      rd_vld_q <= h_vld[NSTEPS];
      g1_vld_q <= rd_vld_q;
      g2_vld_q <= g1_vld_q;
      g3_vld_q <= g2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_u_q    <= s1_u_d;
      s2_side_q <= s2_side_d;
      s3_side_q <= s2_side_q;
      s3_sq_q   <= s3_sq_d;
      s4_side_q <= s4_side_d;
      s4_pl_q   <= s4_pl_d;
      s4_ph_q   <= s4_ph_d;
      s5_side_q <= s4_side_q;
      s5_prod_q <= s5_prod_d;
      s6_side_q <= s6_side_d;
      s6_e_q    <= s6_e_d;
      s6_ge_q   <= s6_ge_d;
      s7_side_q <= s7_side_d;
      s7_e_q    <= s6_e_q;
      s8_side_q <= s7_side_q;
      s8_r_q    <= s8_r_d;
      rd_side_q <= h_side[NSTEPS];
      rd_g_q    <= rd_g_d;
      g1_side_q <= rd_side_q;
      g1_g_q    <= rd_g_q;
      g1_gtp_q  <= g1_gtp_d;
      g1_mtp_q  <= g1_mtp_d;
      g2_side_q <= g1_side_q;
      g2_g_q    <= g1_g_q;
      g2_mp_q   <= g2_mp_d;
      g2_mt_q   <= g2_mt_d;
      g3_res_q  <= g3_res_d;
    end
  end

  assign vld_o = g3_vld_q;
  assign res_o = g3_res_q;

endmodule

// ===== hdl/gfmg_skid.sv =====
// output register with one skid entry, decoupling the pipe enable from the receiver
module gfmg_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  gfmg_pkg::res_t data_i,
  output logic           ready_o,
  output logic           out_valid_o,
  output gfmg_pkg::res_t out_data_o,
  input  logic           out_ready_i
);
  import gfmg_pkg::*;

  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q;
  logic take, out_free;

  assign ready_o  = !skid_vld_q;
  assign take     = ready_o && vld_i;
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || take;
      skid_vld_q <= 1'b0;
    end else if (take) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (take) begin
        out_q <= data_i;
      end
    end else if (take) begin
      skid_q <= data_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/gaussian_factor_mean_gradient.sv =====
// top level: configuration registers, arithmetic pipeline and output buffer
//
// Gaussian bump with parameter gradient in signed Q16.16. Each input item x_value
// gives one result item: mean_value = exp(-tau*u*u/2) in Q1.16 with u = x - mu,
// grad_mu = G*tau*u and grad_tau = -u*u*G/2 (both saturating), and at_mode when x
// equals mu. Input and result channels use valid/ready; an item moves when both
// are high. mu (index 0) and tau (index 1) are written through cfg_we_i; the user
// must write them only while the block is idle; the block does not enforce it.
// A zero tau write is ignored and other indexes do nothing. Throughput is one item
// per cycle while in_ready_o is high. The pipe: offset, square, split tau product,
// exponent check and ln2 reduction (8 stages), nine horner steps of 3 stages each
// (multiply, reciprocal multiply, correction), rounding and 3 gradient stages.
// A result held back by the receiver sits in the output register while a second
// one goes to a skid entry; only then does in_ready_o drop and the whole pipe
// freeze in place, so nothing is lost or repeated.
// Reset clears all valid bits and sets mu to 0 and tau to 1.0.
module gaussian_factor_mean_gradient (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [gfmg_pkg::XW-1:0]    x_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gfmg_pkg::GW-1:0]           mean_value_o,
  output logic signed [gfmg_pkg::XW-1:0]    grad_mu_o,
  output logic signed [gfmg_pkg::XW-1:0]    grad_tau_o,
  output logic                              at_mode_o,
  input  logic                              cfg_we_i,
  input  logic [gfmg_pkg::CFG_IW-1:0]       cfg_idx_i,
  input  logic [gfmg_pkg::CFG_DW-1:0]       cfg_wdata_i
);
  import gfmg_pkg::*;

  logic signed [XW-1:0] mu_q;
  logic [TAUW-1:0]      tau_q;
  logic                 en;
  logic                 pipe_vld;
  res_t                 pipe_res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q  <= '0;
      tau_q <= TAU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MEAN: mu_q <= cfg_wdata_i[XW-1:0];
        REG_PREC: begin
          // tau stays positive
          if (cfg_wdata_i[TAUW-1:0] != '0) tau_q <= cfg_wdata_i[TAUW-1:0];
        end
        default: ;
      endcase
    end
  end

  gfmg_kernel u_kernel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .x_value_i  (x_value_i),
    .mu_i       (mu_q),
    .tau_i      (tau_q),
    .vld_o      (pipe_vld),
    .res_o      (pipe_res)
  );

  gfmg_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (pipe_vld),
    .data_i      (pipe_res),
    .ready_o     (en),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_ready_i (out_ready_i)
  );

  assign in_ready_o   = en;
  assign mean_value_o = out_res.mean;
  assign grad_mu_o    = out_res.grad_mu;
  assign grad_tau_o   = out_res.grad_tau;
  assign at_mode_o    = out_res.mode;

  a_mode_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && at_mode_o) |->
      (mean_value_o == (GW'(1) << FRAC_BITS) && grad_mu_o == '0 && grad_tau_o == '0))
    else $error("item at the mode without unit mean and zero gradients");

  a_flush_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mean_value_o == '0) |-> (grad_mu_o == '0 && grad_tau_o == '0))
    else $error("zero mean with a nonzero gradient");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while no result waits");

endmodule
